// ----- src/ifs_pkg.sv -----
`default_nettype none

package ifs_pkg;

    // Architecture constants
    localparam int MAX_RULES       = 8;
    localparam int COORD_FRAC_BITS = 16;
    localparam int RANDOM_BITS     = 16;
    localparam int DIM_BITS        = 12;
    localparam int PROB_FRAC_BITS  = 16;
    localparam int WORDS_PER_RULE  = 6;

    // Field widths
    localparam int COORD_W     = 24;
    localparam int RULE_W      = $clog2(MAX_RULES);
    localparam int WSEL_W      = 3;
    localparam int DIM_W       = DIM_BITS;
    localparam int RAND_W      = RANDOM_BITS;
    localparam int CFG_DIM_W   = 13;
    localparam int CFG_OFS_W   = 12;
    localparam int CFG_RULES_W = 4;
    localparam int CFG_IDX_W   = 3;
    localparam int CFG_DATA_W  = 13;

    // Derived datapath widths
    localparam int PROB_W  = PROB_FRAC_BITS + 1;
    localparam int CDF_W   = PROB_W + $clog2(MAX_RULES);
    localparam int CMP_W   = CDF_W + RANDOM_BITS;
    localparam int PROD_W  = 2 * COORD_W;
    localparam int AFF_W   = PROD_W + 1;
    localparam int PIX_W   = COORD_W + CFG_DIM_W + 1;
    localparam int POS_W   = PIX_W - COORD_FRAC_BITS + 2;

    localparam int PROB_ONE   = 1 << PROB_FRAC_BITS;
    localparam int DIM_CAP    = 1 << DIM_BITS;
    localparam int TRUNC_BIAS = (1 << COORD_FRAC_BITS) - 1;
    localparam int COORD_MAX  = (1 << (COORD_W - 1)) - 1;
    localparam int COORD_MIN  = -(1 << (COORD_W - 1));

    // Item kinds
    localparam logic KIND_LOAD = 1'b0;
    localparam logic KIND_STEP = 1'b1;

    // Table word selects
    localparam logic [WSEL_W-1:0] WSEL_A    = 3'd0;
    localparam logic [WSEL_W-1:0] WSEL_B    = 3'd1;
    localparam logic [WSEL_W-1:0] WSEL_C    = 3'd2;
    localparam logic [WSEL_W-1:0] WSEL_D    = 3'd3;
    localparam logic [WSEL_W-1:0] WSEL_E    = 3'd4;
    localparam logic [WSEL_W-1:0] WSEL_F    = 3'd5;
    localparam logic [WSEL_W-1:0] WSEL_PROB = 3'd6;

    // Configuration register indexes
    localparam logic [CFG_IDX_W-1:0] CFG_IMAGE_WIDTH  = 3'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_IMAGE_HEIGHT = 3'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_SCALE_X      = 3'd2;
    localparam logic [CFG_IDX_W-1:0] CFG_SCALE_Y      = 3'd3;
    localparam logic [CFG_IDX_W-1:0] CFG_COL_BIAS     = 3'd4;
    localparam logic [CFG_IDX_W-1:0] CFG_ROW_BIAS     = 3'd5;
    localparam logic [CFG_IDX_W-1:0] CFG_ACTIVE_RULES = 3'd6;

    // Configuration reset values
    localparam logic [CFG_DIM_W-1:0]   RST_IMAGE_WIDTH  = 13'd1024;
    localparam logic [CFG_DIM_W-1:0]   RST_IMAGE_HEIGHT = 13'd1024;
    localparam logic [CFG_DIM_W-1:0]   RST_SCALE        = 13'd200;
    localparam logic [CFG_OFS_W-1:0]   RST_OFFSET       = 12'd0;
    localparam logic [CFG_RULES_W-1:0] RST_ACTIVE_RULES = 4'd4;

    // Controller to datapath commands
    typedef struct packed {
        logic load;      // write one table word
        logic pick;      // select rule, read its coefficient row
        logic mul;       // affine products
        logic sum;       // new point
        logic pmul;      // scaling products
        logic out_load;  // load result register
    } ifs_cmd_t;

endpackage

`default_nettype wire

// ----- src/ifs_item_if.sv -----
`default_nettype none

interface ifs_item_if;
    logic                                 valid;
    logic                                 ready;
    logic                                 kind;
    logic [ifs_pkg::RULE_W-1:0]           rule_slot;
    logic [ifs_pkg::WSEL_W-1:0]           word_select;
    logic signed [ifs_pkg::COORD_W-1:0]   load_value;
    logic [ifs_pkg::RAND_W-1:0]           random_fraction;

    modport source (output valid, kind, rule_slot, word_select, load_value,
                    random_fraction, input ready);
    modport sink (input valid, kind, rule_slot, word_select, load_value,
                  random_fraction, output ready);
endinterface

`default_nettype wire

// ----- src/ifs_result_if.sv -----
`default_nettype none

interface ifs_result_if;
    logic                                 valid;
    logic                                 ready;
    logic [ifs_pkg::DIM_W-1:0]            pixel_row;
    logic [ifs_pkg::DIM_W-1:0]            pixel_col;
    logic [ifs_pkg::RULE_W-1:0]           rule_used;
    logic signed [ifs_pkg::COORD_W-1:0]   point_x;
    logic signed [ifs_pkg::COORD_W-1:0]   point_y;

    modport source (output valid, pixel_row, pixel_col, rule_used, point_x, point_y,
                    input ready);
    modport sink (input valid, pixel_row, pixel_col, rule_used, point_x, point_y,
                  output ready);
endinterface

`default_nettype wire

// ----- src/ifs_cfg_if.sv -----
`default_nettype none

interface ifs_cfg_if;
    logic                                 valid;
    logic                                 ready;
    logic [ifs_pkg::CFG_IDX_W-1:0]        index;
    logic [ifs_pkg::CFG_DATA_W-1:0]       data;

    modport source (output valid, index, data, input ready);
    modport sink (input valid, index, data, output ready);
endinterface

`default_nettype wire

// ----- src/ifs_ctrl.sv -----
`default_nettype none

module ifs_ctrl (
    input  wire logic          clk,
    input  wire logic          rst_n,
    input  wire logic          in_valid,
    input  wire logic          in_kind,
    input  wire logic          out_ready,
    output logic               in_ready,
    output logic               out_valid,
    output ifs_pkg::ifs_cmd_t  cmd
);
    import ifs_pkg::*;

    localparam logic [2:0] ST_IDLE = 3'd0;
    localparam logic [2:0] ST_MUL  = 3'd1;
    localparam logic [2:0] ST_SUM  = 3'd2;
    localparam logic [2:0] ST_PMUL = 3'd3;
    localparam logic [2:0] ST_OUT  = 3'd4;

    logic [2:0] state_reg, state_next;
    logic       out_valid_reg, out_valid_next;
    logic       accept;

    assign in_ready  = (state_reg == ST_IDLE);
    assign out_valid = out_valid_reg;
    assign accept    = in_valid && in_ready;

    // Sequencer: one step walks through all states, a load stays in idle
    always_comb
    begin
        state_next = state_reg;
        cmd        = '0;
        case (state_reg)
            ST_IDLE:
            begin
                if (accept && in_kind == KIND_LOAD)
                begin
                    cmd.load = 1'b1;
                end
                else if (accept && in_kind == KIND_STEP)
                begin
                    cmd.pick   = 1'b1;
                    state_next = ST_MUL;
                end
            end
            ST_MUL:
            begin
                cmd.mul    = 1'b1;
                state_next = ST_SUM;
            end
            ST_SUM:
            begin
                cmd.sum    = 1'b1;
                state_next = ST_PMUL;
            end
            ST_PMUL:
            begin
                cmd.pmul   = 1'b1;
                state_next = ST_OUT;
            end
            ST_OUT:
            begin
                // wait until the result register is free
                if (!out_valid_reg || out_ready)
                begin
                    cmd.out_load = 1'b1;
                    state_next   = ST_IDLE;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    // Result valid: set on load, cleared on transfer
    always_comb
    begin
        out_valid_next = out_valid_reg;
        if (cmd.out_load)
        begin
            out_valid_next = 1'b1;
        end
        else if (out_ready)
        begin
            out_valid_next = 1'b0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= ST_IDLE;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            out_valid_reg <= out_valid_next;
        end
    end

endmodule

`default_nettype wire

// ----- src/ifs_datapath.sv -----
`default_nettype none

module ifs_datapath (
    input  wire logic                                  clk,
    input  wire logic                                  rst_n,
    input  wire ifs_pkg::ifs_cmd_t                     cmd,
    input  wire logic [ifs_pkg::RULE_W-1:0]            rule_slot,
    input  wire logic [ifs_pkg::WSEL_W-1:0]            word_select,
    input  wire logic signed [ifs_pkg::COORD_W-1:0]    load_value,
    input  wire logic [ifs_pkg::RAND_W-1:0]            random_fraction,
    input  wire logic                                  cfg_we,
    input  wire logic [ifs_pkg::CFG_IDX_W-1:0]         cfg_index,
    input  wire logic [ifs_pkg::CFG_DATA_W-1:0]        cfg_data,
    output logic [ifs_pkg::DIM_W-1:0]                  pixel_row,
    output logic [ifs_pkg::DIM_W-1:0]                  pixel_col,
    output logic [ifs_pkg::RULE_W-1:0]                 rule_used,
    output logic signed [ifs_pkg::COORD_W-1:0]         point_x,
    output logic signed [ifs_pkg::COORD_W-1:0]         point_y
);
    import ifs_pkg::*;

    localparam logic signed [AFF_W-1:0] AFF_MAX = AFF_W'(COORD_MAX);
    localparam logic signed [AFF_W-1:0] AFF_MIN = AFF_W'(COORD_MIN);
    localparam logic signed [POS_W-1:0] POS_ONE = POS_W'(1);

    function automatic logic signed [COORD_W-1:0] sat_coord(
        input logic signed [AFF_W-1:0] v
    );
        logic signed [COORD_W-1:0] r;
        if (v > AFF_MAX)
        begin
            r = COORD_W'(COORD_MAX);
        end
        else if (v < AFF_MIN)
        begin
            r = COORD_W'(COORD_MIN);
        end
        else
        begin
            r = v[COORD_W-1:0];
        end
        return r;
    endfunction

    function automatic logic [CFG_DIM_W-1:0] dim_limit(input logic [CFG_DIM_W-1:0] v);
        logic [CFG_DIM_W-1:0] r;
        if (v == '0)
        begin
            r = CFG_DIM_W'(1);
        end
        else if (v > CFG_DIM_W'(DIM_CAP))
        begin
            r = CFG_DIM_W'(DIM_CAP);
        end
        else
        begin
            r = v;
        end
        return r;
    endfunction

    // Configuration registers
    logic [CFG_DIM_W-1:0]   width_reg, height_reg, scale_x_reg, scale_y_reg;
    logic [CFG_OFS_W-1:0]   col_bias_reg, row_bias_reg;
    logic [CFG_RULES_W-1:0] active_rules_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            width_reg        <= RST_IMAGE_WIDTH;
            height_reg       <= RST_IMAGE_HEIGHT;
            scale_x_reg      <= RST_SCALE;
            scale_y_reg      <= RST_SCALE;
            col_bias_reg     <= RST_OFFSET;
            row_bias_reg     <= RST_OFFSET;
            active_rules_reg <= RST_ACTIVE_RULES;
        end
        else if (cfg_we)
        begin
            case (cfg_index)
                CFG_IMAGE_WIDTH:  width_reg        <= cfg_data[CFG_DIM_W-1:0];
                CFG_IMAGE_HEIGHT: height_reg       <= cfg_data[CFG_DIM_W-1:0];
                CFG_SCALE_X:      scale_x_reg      <= cfg_data[CFG_DIM_W-1:0];
                CFG_SCALE_Y:      scale_y_reg      <= cfg_data[CFG_DIM_W-1:0];
                CFG_COL_BIAS:     col_bias_reg     <= cfg_data[CFG_OFS_W-1:0];
                CFG_ROW_BIAS:     row_bias_reg     <= cfg_data[CFG_OFS_W-1:0];
                CFG_ACTIVE_RULES: active_rules_reg <= cfg_data[CFG_RULES_W-1:0];
                default:          ;
            endcase
        end
    end

    // Load decode
    logic              slot_ok, coef_we, prob_we;
    logic [PROB_W-1:0] prob_sat;

    assign slot_ok = (int'(rule_slot) < MAX_RULES);
    assign coef_we = cmd.load && slot_ok && (int'(word_select) < WORDS_PER_RULE);
    assign prob_we = cmd.load && slot_ok && (word_select == WSEL_PROB);

    always_comb
    begin
        if (load_value < 0)
        begin
            prob_sat = '0;
        end
        else if (load_value > COORD_W'(PROB_ONE))
        begin
            prob_sat = PROB_W'(PROB_ONE);
        end
        else
        begin
            prob_sat = load_value[PROB_W-1:0];
        end
    end

    // Probability table, cleared by reset
    logic [PROB_W-1:0] prob_reg [MAX_RULES];

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            for (int i = 0; i < MAX_RULES; i++)
            begin
                prob_reg[i] <= '0;
            end
        end
        else if (prob_we)
        begin
            prob_reg[rule_slot] <= prob_sat;
        end
    end

    // Rule pick: first active rule whose running sum exceeds the fraction
    logic [CFG_RULES_W-1:0] n_eff;
    logic [RULE_W-1:0]      pick_rule;

    always_comb
    begin
        if (active_rules_reg == '0)
        begin
            n_eff = CFG_RULES_W'(1);
        end
        else if (int'(active_rules_reg) > MAX_RULES)
        begin
            n_eff = CFG_RULES_W'(MAX_RULES);
        end
        else
        begin
            n_eff = active_rules_reg;
        end
    end

    always_comb
    begin : pick_blk
        logic [CDF_W-1:0] cdf;
        logic [CMP_W-1:0] rnd_cmp;
        logic             found;
        cdf       = '0;
        found     = 1'b0;
        rnd_cmp   = CMP_W'(random_fraction) << PROB_FRAC_BITS;
        pick_rule = RULE_W'(n_eff - CFG_RULES_W'(1));
        for (int j = 0; j < MAX_RULES; j++)
        begin
            if (j < int'(n_eff) && !found)
            begin
                cdf = cdf + CDF_W'(prob_reg[j]);
                if (rnd_cmp < (CMP_W'(cdf) << RANDOM_BITS))
                begin
                    pick_rule = RULE_W'(j);
                    found     = 1'b1;
                end
            end
        end
    end

    // Coefficient memory, one row per rule, with a valid bit per word
    logic [WORDS_PER_RULE-1:0][COORD_W-1:0] coef_mem [MAX_RULES];
    logic signed [COORD_W-1:0] row_reg  [WORDS_PER_RULE];
    logic [WORDS_PER_RULE-1:0] coef_vld_reg [MAX_RULES];
    logic [WORDS_PER_RULE-1:0] row_vld_reg;
    logic [RULE_W-1:0]         rule_reg;

    always_ff @(posedge clk)
    begin
        if (coef_we)
        begin
            coef_mem[rule_slot][word_select] <= load_value;
        end
        if (cmd.pick)
        begin
            for (int w = 0; w < WORDS_PER_RULE; w++)
            begin
                row_reg[w] <= coef_mem[pick_rule][w];
            end
            rule_reg <= pick_rule;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            for (int i = 0; i < MAX_RULES; i++)
            begin
                coef_vld_reg[i] <= '0;
            end
            row_vld_reg <= '0;
        end
        else
        begin
            if (coef_we)
            begin
                coef_vld_reg[rule_slot][word_select] <= 1'b1;
            end
            if (cmd.pick)
            begin
                row_vld_reg <= coef_vld_reg[pick_rule];
            end
        end
    end

    // Never-written words read as zero
    logic signed [COORD_W-1:0] coef [WORDS_PER_RULE];

    always_comb
    begin
        for (int w = 0; w < WORDS_PER_RULE; w++)
        begin
            coef[w] = row_vld_reg[w] ? row_reg[w] : '0;
        end
    end

    // Affine products
    logic signed [COORD_W-1:0] x_reg, y_reg;
    logic signed [PROD_W-1:0]  ax_reg, by_reg, cx_reg, dy_reg;

    always_ff @(posedge clk)
    begin
        if (cmd.mul)
        begin
            ax_reg <= coef[WSEL_A] * x_reg;
            by_reg <= coef[WSEL_B] * y_reg;
            cx_reg <= coef[WSEL_C] * x_reg;
            dy_reg <= coef[WSEL_D] * y_reg;
        end
    end

    // New point: floor shift, add offset term, saturate
    logic signed [AFF_W-1:0] nx, ny;

    assign nx = ((AFF_W'(ax_reg) + AFF_W'(by_reg)) >>> COORD_FRAC_BITS)
                + AFF_W'(coef[WSEL_E]);
    assign ny = ((AFF_W'(cx_reg) + AFF_W'(dy_reg)) >>> COORD_FRAC_BITS)
                + AFF_W'(coef[WSEL_F]);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            x_reg <= '0;
            y_reg <= '0;
        end
        else if (cmd.sum)
        begin
            x_reg <= sat_coord(nx);
            y_reg <= sat_coord(ny);
        end
    end

    // Scaling products
    logic signed [CFG_DIM_W:0] sx_s, sy_s;
    logic signed [PIX_W-1:0]   px_reg, py_reg;

    assign sx_s = signed'({1'b0, scale_x_reg});
    assign sy_s = signed'({1'b0, scale_y_reg});

    always_ff @(posedge clk)
    begin
        if (cmd.pmul)
        begin
            px_reg <= x_reg * sx_s;
            py_reg <= y_reg * sy_s;
        end
    end

    // Pixel: truncate toward zero, add offsets, flip row, out of range maps to last column/row
    logic signed [PIX_W-1:0]   px_adj, py_adj;
    logic signed [POS_W-1:0]   col_v, t_v, row_v, w_s, h_s;
    logic [CFG_DIM_W-1:0]      w_lim, h_lim, w_m1, h_m1;
    logic [DIM_W-1:0]          col_sel, row_sel;

    assign px_adj = px_reg[PIX_W-1] ? px_reg + PIX_W'(TRUNC_BIAS) : px_reg;
    assign py_adj = py_reg[PIX_W-1] ? py_reg + PIX_W'(TRUNC_BIAS) : py_reg;

    assign w_lim = dim_limit(width_reg);
    assign h_lim = dim_limit(height_reg);
    assign w_m1  = w_lim - CFG_DIM_W'(1);
    assign h_m1  = h_lim - CFG_DIM_W'(1);
    assign w_s   = signed'(POS_W'(w_lim));
    assign h_s   = signed'(POS_W'(h_lim));

    assign col_v = POS_W'(px_adj >>> COORD_FRAC_BITS) + signed'(POS_W'(col_bias_reg));
    assign t_v   = POS_W'(py_adj >>> COORD_FRAC_BITS) + signed'(POS_W'(row_bias_reg));
    assign row_v = h_s - t_v - POS_ONE;

    assign col_sel = (col_v >= 0 && col_v < w_s) ? col_v[DIM_W-1:0] : w_m1[DIM_W-1:0];
    assign row_sel = (row_v >= 0 && row_v < h_s) ? row_v[DIM_W-1:0] : h_m1[DIM_W-1:0];

    // Result register
    always_ff @(posedge clk)
    begin
        if (cmd.out_load)
        begin
            pixel_row <= row_sel;
            pixel_col <= col_sel;
            rule_used <= rule_reg;
            point_x   <= x_reg;
            point_y   <= y_reg;
        end
    end

endmodule

`default_nettype wire

// ----- src/ifs_chaos_game_point_plotter_unit.sv -----
`default_nettype none

// Chaos-game point plotter for an iterated function system. A load item
// (kind 0) writes one Q8.16 coefficient or one probability of a rule and
// yields no result. A step item (kind 1) picks the first active rule whose
// running probability sum exceeds the random fraction (the last active rule
// if none does), moves the kept point through that rule's affine map with
// saturation, and returns the pixel (last row or column when out of range),
// the rule and the new point. A step runs, in order: rule pick and
// coefficient row read, the four affine multiplies, the saturating add that
// updates the point, the scaling multiplies, then pixel mapping into the
// result register, which waits until that register is free.
// The point feeds back into the next step's multiplies, so items are worked
// one at a time. The result register lets the next item be taken while a
// result still waits. Configuration writes are always taken (ready is high)
// and belong to idle periods; table entries and the point reset to zero.
module ifs_chaos_game_point_plotter_unit (
    input wire logic      clk,
    input wire logic      rst_n,
    ifs_item_if.sink      item,
    ifs_result_if.source  result,
    ifs_cfg_if.sink       cfg
);
    import ifs_pkg::*;

    ifs_cmd_t cmd;

    assign cfg.ready = 1'b1;

    // Sequencer
    ifs_ctrl u_ctrl (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (item.valid),
        .in_kind   (item.kind),
        .out_ready (result.ready),
        .in_ready  (item.ready),
        .out_valid (result.valid),
        .cmd       (cmd)
    );

    // Table, point and pixel arithmetic
    ifs_datapath u_datapath (
        .clk             (clk),
        .rst_n           (rst_n),
        .cmd             (cmd),
        .rule_slot       (item.rule_slot),
        .word_select     (item.word_select),
        .load_value      (item.load_value),
        .random_fraction (item.random_fraction),
        .cfg_we          (cfg.valid),
        .cfg_index       (cfg.index),
        .cfg_data        (cfg.data),
        .pixel_row       (result.pixel_row),
        .pixel_col       (result.pixel_col),
        .rule_used       (result.rule_used),
        .point_x         (result.point_x),
        .point_y         (result.point_y)
    );

endmodule

`default_nettype wire
